// ===== sv/dhe_pkg.sv =====
package dhe_pkg;

   localparam int TABLE_DEPTH  = 512;
   localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
   localparam int MAX_CODE_LEN = 24;
   localparam int WORD_BITS    = 16;
   localparam int WORD_SH      = $clog2(WORD_BITS);
   localparam int CODE_BITS    = 24;
   localparam int LEN_BITS     = 5;
   localparam int CODE_CAP     = (MAX_CODE_LEN < CODE_BITS) ? MAX_CODE_LEN : CODE_BITS;
   localparam int SEG_BITS     = 2 * CODE_BITS + WORD_BITS;
   localparam int SEG_LW       = 7;
   localparam int PEND_BITS    = WORD_BITS - 1;
   localparam int OUT_WORDS    = 5;
   localparam int BUF_BITS     = OUT_WORDS * WORD_BITS;
   localparam int CNT_W        = 3;

   typedef enum logic [1:0] {
      CSR_KEY_MIN,
      CSR_ESCAPE_KEY,
      CSR_ESCAPE_BITS,
      CSR_ESCAPE_LEN
   } csr_index_type;

   typedef struct packed {
      logic                  req_type;
      logic [15:0]           sample;
      logic                  read_start;
      logic                  read_end;
      logic [8:0]            entry_index;
      logic                  entry_valid;
      logic [LEN_BITS-1:0]   entry_len;
      logic [CODE_BITS-1:0]  entry_bits;
   } enc_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]  packed_word;
      logic                  stream_done;
      logic                  last;
   } enc_rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [LEN_BITS-1:0]   len;
      logic [CODE_BITS-1:0]  bits;
   } entry_type;

   // right-aligned bit string for one item, terminator included on the last item of a stream
   typedef struct packed {
      logic [SEG_BITS-1:0]   bits;
      logic [SEG_LW-1:0]     len;
      logic                  flush;
   } seg_type;

   function automatic logic [LEN_BITS-1:0] clip_len(input logic [LEN_BITS-1:0] n);
      if (n > LEN_BITS'(CODE_CAP)) begin
         return LEN_BITS'(CODE_CAP);
      end
      return n;
   endfunction

   function automatic logic [CODE_BITS-1:0] low_mask(input logic [LEN_BITS-1:0] n);
      logic [CODE_BITS:0] m;
      m = ((CODE_BITS + 1)'(1) << n) - (CODE_BITS + 1)'(1);
      return m[CODE_BITS-1:0];
   endfunction

endpackage

// ===== sv/dhe_packer.sv =====
module dhe_packer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  seg_valid,
   output logic                  seg_ready,
   input  dhe_pkg::seg_type      seg,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dhe_pkg::enc_rsp_type  rsp_data
);

   localparam int CombBits = dhe_pkg::PEND_BITS + dhe_pkg::SEG_BITS;

   logic [dhe_pkg::PEND_BITS-1:0] pend_ff, pend_in;
   logic [dhe_pkg::WORD_SH-1:0]   pcnt_ff, pcnt_in;
   logic [dhe_pkg::BUF_BITS-1:0]  obuf_ff, obuf_in;
   logic [dhe_pkg::CNT_W-1:0]     left_ff, left_in;
   logic                          done_ff, done_in;

   logic [CombBits-1:0]            comb;
   logic [dhe_pkg::SEG_LW-1:0]     tot;
   logic [dhe_pkg::BUF_BITS-1:0]   align;
   logic [dhe_pkg::WORD_SH-1:0]    rem;
   logic [dhe_pkg::CNT_W-1:0]      nwords;
   logic [dhe_pkg::PEND_BITS-1:0]  pmask;
   logic                           free;

   assign comb   = (CombBits'(pend_ff) << seg.len) | CombBits'(seg.bits);
   assign tot    = dhe_pkg::SEG_LW'(pcnt_ff) + seg.len;
   assign align  = dhe_pkg::BUF_BITS'(comb)
                   << (dhe_pkg::SEG_LW'(dhe_pkg::BUF_BITS) - tot);
   assign rem    = tot[dhe_pkg::WORD_SH-1:0];
   assign nwords = dhe_pkg::CNT_W'(tot >> dhe_pkg::WORD_SH)
                   + dhe_pkg::CNT_W'(seg.flush && (rem != '0));
   assign pmask  = dhe_pkg::PEND_BITS'((dhe_pkg::WORD_BITS'(1) << rem)
                                       - dhe_pkg::WORD_BITS'(1));

   assign free      = (left_ff == '0) || ((left_ff == dhe_pkg::CNT_W'(1)) && rsp_ready);
   assign seg_ready = free;

   always_comb begin
      pend_in = pend_ff;
      pcnt_in = pcnt_ff;
      obuf_in = obuf_ff;
      left_in = left_ff;
      done_in = done_ff;
      if (rsp_valid && rsp_ready) begin
         left_in = left_ff - dhe_pkg::CNT_W'(1);
         obuf_in = obuf_ff << dhe_pkg::WORD_BITS;
      end
      if (seg_valid && free) begin
         obuf_in = align;
         left_in = nwords;
         done_in = seg.flush;
         if (seg.flush) begin
            pend_in = '0;
            pcnt_in = '0;
         end else begin
            pend_in = comb[dhe_pkg::PEND_BITS-1:0] & pmask;
            pcnt_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         pcnt_ff <= '0;
         left_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         pcnt_ff <= pcnt_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      obuf_ff <= obuf_in;
      done_ff <= done_in;
   end

   assign rsp_valid            = (left_ff != '0);
   assign rsp_data.packed_word = obuf_ff[dhe_pkg::BUF_BITS-1 -: dhe_pkg::WORD_BITS];
   assign rsp_data.last        = (left_ff == dhe_pkg::CNT_W'(1));
   assign rsp_data.stream_done = done_ff && (left_ff == dhe_pkg::CNT_W'(1));

endmodule

// ===== sv/delta_huffman_escape_encoder_unit.sv =====
// Delta/variable-length encoder with escape. Sample items (req_type 0) are
// differenced against the previous sample, looked up in a 512-entry code
// memory and packed MSB first into 16-bit words; load items (req_type 1)
// write one code memory entry and produce no words. The first word of an
// item leaves the output word register, after the stage 1 and stage 2
// registers. Items overlap in a three-stage pipeline; the rate is set by the
// output word register, which hands out one word per cycle while rsp_ready
// is high, and takes the next item only once its last word is taken; an
// item completes N words, N from 0 to 5. After reset the unit clears the
// code memory valid bits one entry per cycle, holding req_ready low until
// all 512 are clear; entries never loaded then count as invalid and are escaped.
module delta_huffman_escape_encoder_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dhe_pkg::enc_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dhe_pkg::enc_rsp_type  rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [dhe_pkg::CODE_BITS-1:0] csr_wdata
);

   logic [15:0]                     key_min_ff;
   logic [15:0]                     esc_key_ff;
   logic [dhe_pkg::CODE_BITS-1:0]   esc_bits_ff;
   logic [dhe_pkg::LEN_BITS-1:0]    esc_len_ff;
   logic [15:0]                     prev_ff;

   dhe_pkg::entry_type code_mem [dhe_pkg::TABLE_DEPTH];

   logic                          clr_busy_ff;
   logic [dhe_pkg::TABLE_AW-1:0]  clr_addr_ff;

   logic                 s1_v_ff, s1_v_in;
   logic [15:0]          s1_diff_ff;
   logic                 s1_hit_ff;
   logic                 s1_end_ff;
   dhe_pkg::entry_type   ent_q_ff;

   logic                 s2_v_ff, s2_v_in;
   dhe_pkg::seg_type     s2_seg_ff;

   logic                 req_fire, enc_fire, load_fire;
   logic                 s1_go, s2_go, seg_ready;
   logic [15:0]          diff;
   logic [17:0]          slot_full;
   logic                 in_range;

   logic [dhe_pkg::LEN_BITS-1:0]   clen, elen;
   logic [dhe_pkg::CODE_BITS-1:0]  code, esc;
   logic                           coded;
   logic [dhe_pkg::SEG_BITS-1:0]   body;
   logic [dhe_pkg::SEG_LW-1:0]     blen;
   dhe_pkg::seg_type               seg;

   assign req_fire  = req_valid && req_ready;
   assign enc_fire  = req_fire && !req_data.req_type;
   assign load_fire = req_fire && req_data.req_type;

   assign s2_go     = s2_v_ff && seg_ready;
   assign s1_go     = s1_v_ff && (!s2_v_ff || s2_go);
   assign req_ready = !clr_busy_ff && (!s1_v_ff || s1_go);

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         key_min_ff  <= 16'hFF6A;
         esc_key_ff  <= 16'd251;
         esc_bits_ff <= '0;
         esc_len_ff  <= dhe_pkg::LEN_BITS'(1);
      end else if (csr_we) begin
         unique case (dhe_pkg::csr_index_type'(csr_index))
            dhe_pkg::CSR_KEY_MIN:     key_min_ff  <= csr_wdata[15:0];
            dhe_pkg::CSR_ESCAPE_KEY:  esc_key_ff  <= csr_wdata[15:0];
            dhe_pkg::CSR_ESCAPE_BITS: esc_bits_ff <= csr_wdata;
            dhe_pkg::CSR_ESCAPE_LEN:  esc_len_ff  <= csr_wdata[dhe_pkg::LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // difference and table slot
   assign diff      = req_data.read_start ? 16'd0 : (req_data.sample - prev_ff);
   assign slot_full = {{2{diff[15]}}, diff} - {{2{key_min_ff[15]}}, key_min_ff};
   assign in_range  = !slot_full[17] && (slot_full < 18'(dhe_pkg::TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (enc_fire) begin
         prev_ff <= req_data.sample;
      end
   end

   // valid bits cleared one entry per cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + dhe_pkg::TABLE_AW'(1);
         if (clr_addr_ff == dhe_pkg::TABLE_AW'(dhe_pkg::TABLE_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // code memory
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         code_mem[clr_addr_ff] <= '0;
      end else if (load_fire && (10'(req_data.entry_index) < 10'(dhe_pkg::TABLE_DEPTH))) begin
         code_mem[req_data.entry_index[dhe_pkg::TABLE_AW-1:0]] <= '{
            valid: req_data.entry_valid,
            len:   req_data.entry_len,
            bits:  req_data.entry_bits
         };
      end
   end

   always_ff @(posedge clock) begin
      if (enc_fire) begin
         ent_q_ff   <= code_mem[slot_full[dhe_pkg::TABLE_AW-1:0]];
         s1_diff_ff <= diff;
         s1_hit_ff  <= in_range && (diff != esc_key_ff);
         s1_end_ff  <= req_data.read_end;
      end
   end

   always_comb begin
      s1_v_in = s1_v_ff;
      if (enc_fire) begin
         s1_v_in = 1'b1;
      end else if (s1_go) begin
         s1_v_in = 1'b0;
      end
   end

   // bit string for the item: code, or escape plus raw difference, then terminator on the last item
   always_comb begin
      clen  = dhe_pkg::clip_len(ent_q_ff.len);
      elen  = dhe_pkg::clip_len(esc_len_ff);
      code  = ent_q_ff.bits & dhe_pkg::low_mask(clen);
      esc   = esc_bits_ff & dhe_pkg::low_mask(elen);
      coded = s1_hit_ff && ent_q_ff.valid;
      if (coded) begin
         body = dhe_pkg::SEG_BITS'(code);
         blen = dhe_pkg::SEG_LW'(clen);
      end else begin
         body = (dhe_pkg::SEG_BITS'(esc) << dhe_pkg::WORD_BITS)
                | dhe_pkg::SEG_BITS'(s1_diff_ff);
         blen = dhe_pkg::SEG_LW'(elen) + dhe_pkg::SEG_LW'(dhe_pkg::WORD_BITS);
      end
      seg.flush = s1_end_ff;
      if (s1_end_ff) begin
         seg.bits = (body << elen) | dhe_pkg::SEG_BITS'(esc);
         seg.len  = blen + dhe_pkg::SEG_LW'(elen);
      end else begin
         seg.bits = body;
         seg.len  = blen;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_seg_ff <= seg;
      end
   end

   always_comb begin
      s2_v_in = s2_v_ff;
      if (s1_go) begin
         s2_v_in = 1'b1;
      end else if (s2_go) begin
         s2_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   dhe_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .seg_valid (s2_v_ff),
      .seg_ready (seg_ready),
      .seg       (s2_seg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/dhe_checker.sv =====
module dhe_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input dhe_pkg::enc_rsp_type  rsp_data
);

   // no word can leave before an item has crossed all three stages
   a_reset_latency: assert property (@(posedge clock)
      reset |-> ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("word out too early after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled word changed");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stream_done |-> rsp_data.last)
      else $error("stream_done on a word that is not last of its item");

   a_handshake_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_ready, rsp_valid}))
      else $error("handshake signal unknown");

endmodule

bind delta_huffman_escape_encoder_unit dhe_checker u_dhe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
